/* rtl/ip_address_text_validator_unit_assert.svh */
// ----------------------------------------------------------------------------
// ip_address_text_validator_unit_assert.svh
// Assertion macros for the address text validator. The macros sample on clk
// of the module that uses them; the first one is also gated by rst.
// ----------------------------------------------------------------------------
`ifndef IP_ADDRESS_TEXT_VALIDATOR_UNIT_ASSERT_SVH
`define IP_ADDRESS_TEXT_VALIDATOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked outside reset only
`define IPAV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked during reset as well
`define IPAV_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IPAV_ASSERT(lbl, prop, msg)
`define IPAV_ASSERT_RST(lbl, prop, msg)
`endif

`endif

/* rtl/ipav_pkg.sv */
// ----------------------------------------------------------------------------
// ipav_pkg
// Types and constants shared by the address text validator modules.
// ----------------------------------------------------------------------------
package ipav_pkg;

  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_DIG0  = 8'h30;
  localparam logic [7:0] CHAR_DIG9  = 8'h39;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;

  localparam int DOT_W    = 3;
  localparam int COLON_W  = 4;
  localparam int LEN4_W   = 3;
  localparam int LEN6_W   = 3;
  localparam int VAL4_W   = 10;

  localparam logic [DOT_W-1:0]   DOT_SAT     = 3'd4;
  localparam logic [DOT_W-1:0]   DOT_NEED    = 3'd3;
  localparam logic [COLON_W-1:0] COLON_SAT   = 4'd8;
  localparam logic [COLON_W-1:0] COLON_NEED  = 4'd7;
  localparam logic [LEN4_W-1:0]  LEN4_SAT    = 3'd4;
  localparam logic [LEN4_W-1:0]  LEN4_MAX    = 3'd3;
  localparam logic [LEN6_W-1:0]  LEN6_SAT    = 3'd5;
  localparam logic [LEN6_W-1:0]  LEN6_MAX    = 3'd4;
  localparam logic [VAL4_W-1:0]  VAL4_MAX    = 10'd255;
  localparam logic [VAL4_W-1:0]  VAL4_RADIX  = 10'd10;

  // byte queue between front and back
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // result buffer in the back end
  localparam int OB_DEPTH = 2;
  localparam int OB_CNT_W = $clog2(OB_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_NEITHER = 2'd0,
    KIND_V4      = 2'd1,
    KIND_V6      = 2'd2
  } kind_t;

  // classified byte
  typedef struct packed {
    logic       last;
    logic       is_dot;
    logic       is_colon;
    logic       is_dec;
    logic       is_hex;
    logic [3:0] digit;
  } tok_t;

endpackage

/* rtl/ipav_classify.sv */
// ----------------------------------------------------------------------------
// ipav_classify
// Front end: sorts one text byte into separator / decimal / hex classes.
// ----------------------------------------------------------------------------
module ipav_classify (
  input  logic [7:0]    char_code,
  input  logic          last,
  output ipav_pkg::tok_t tok
);
  import ipav_pkg::*;

  logic dec;

  assign dec = (char_code >= CHAR_DIG0) && (char_code <= CHAR_DIG9);

  always_comb begin
    tok.last     = last;
    tok.is_dot   = (char_code == CHAR_DOT);
    tok.is_colon = (char_code == CHAR_COLON);
    tok.is_dec   = dec;
    tok.is_hex   = dec || ((char_code >= CHAR_LA) && (char_code <= CHAR_LF))
                       || ((char_code >= CHAR_UA) && (char_code <= CHAR_UF));
    tok.digit    = char_code[3:0];
  end

endmodule

/* rtl/ipav_fifo.sv */
// ----------------------------------------------------------------------------
// ipav_fifo
// Short queue of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
module ipav_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  ipav_pkg::tok_t wr_tok,
  output logic           q_full,
  input  logic           rd,
  output ipav_pkg::tok_t rd_tok,
  output logic           q_empty
);
  import ipav_pkg::*;

  tok_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_full  = (count == QCNT_W'(QDEPTH));
  assign q_empty = (count == '0);
  assign rd_tok  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/ipav_scan.sv */
// ----------------------------------------------------------------------------
// ipav_scan
// Back end: runs both address readings over the byte stream and buffers the
// verdict for each string.
// ----------------------------------------------------------------------------
module ipav_scan (
  input  logic            clk,
  input  logic            rst,
  input  logic            tok_valid,
  input  ipav_pkg::tok_t  tok,
  output logic            tok_pop,
  output ipav_pkg::kind_t kind_out,
  output logic            kind_empty,
  input  logic            kind_pop
);
  import ipav_pkg::*;

  logic [DOT_W-1:0]    dot_count,   dot_next;
  logic [COLON_W-1:0]  colon_count, colon_next;
  logic                v4_ok,       v4_ok_next;
  logic                v6_ok,       v6_ok_next;
  logic [LEN4_W-1:0]   len4,        len4_next;
  logic [VAL4_W-1:0]   val4,        val4_next;
  logic                fz4,         fz4_next;
  logic [LEN6_W-1:0]   len6,        len6_next;

  kind_t               ob [OB_DEPTH];
  kind_t               ob_next [OB_DEPTH];
  logic [OB_CNT_W-1:0] ob_cnt, ob_cnt_next;

  logic  do_pop;
  logic  v4_fin, v6_fin;
  kind_t verdict;

  function automatic logic v4_good(input logic [LEN4_W-1:0] len,
                                   input logic [VAL4_W-1:0] val,
                                   input logic fz);
    return (len >= 3'd1) && (len <= LEN4_MAX) && (val <= VAL4_MAX) &&
           !(fz && (len != 3'd1));
  endfunction

  function automatic logic v6_good(input logic [LEN6_W-1:0] len);
    return (len >= 3'd1) && (len <= LEN6_MAX);
  endfunction

  assign do_pop     = kind_pop && (ob_cnt != '0);
  assign kind_empty = (ob_cnt == '0);
  assign kind_out   = ob[0];
  // a final byte needs a free result slot, counting one leaving this cycle
  assign tok_pop    = tok_valid &&
                      (!tok.last || (ob_cnt != OB_CNT_W'(OB_DEPTH)) || do_pop);

  // per-byte update of both readings
  always_comb begin
    dot_next   = dot_count;
    colon_next = colon_count;
    v4_ok_next = v4_ok;
    v6_ok_next = v6_ok;
    len4_next  = len4;
    val4_next  = val4;
    fz4_next   = fz4;
    len6_next  = len6;

    if (tok.is_dot) begin
      if (!v4_good(len4, val4, fz4)) begin
        v4_ok_next = 1'b0;
      end
      len4_next = '0;
      val4_next = '0;
      fz4_next  = 1'b0;
      if (dot_count < DOT_SAT) begin
        dot_next = dot_count + 1'b1;
      end
    end else if (tok.is_dec) begin
      if (len4 == '0) begin
        fz4_next = (tok.digit == 4'd0);
      end
      if (len4 < LEN4_MAX) begin
        val4_next = VAL4_W'(val4 * VAL4_RADIX) + VAL4_W'(tok.digit);
      end
      if (len4 < LEN4_SAT) begin
        len4_next = len4 + 1'b1;
      end
    end else begin
      v4_ok_next = 1'b0;
    end

    if (tok.is_colon) begin
      if (!v6_good(len6)) begin
        v6_ok_next = 1'b0;
      end
      len6_next = '0;
      if (colon_count < COLON_SAT) begin
        colon_next = colon_count + 1'b1;
      end
    end else if (tok.is_hex) begin
      if (len6 < LEN6_SAT) begin
        len6_next = len6 + 1'b1;
      end
    end else begin
      v6_ok_next = 1'b0;
    end
  end

  // verdict after closing the open groups
  assign v4_fin = v4_ok_next && v4_good(len4_next, val4_next, fz4_next);
  assign v6_fin = v6_ok_next && v6_good(len6_next);

  always_comb begin
    priority if (dot_next == DOT_NEED) begin
      verdict = v4_fin ? KIND_V4 : KIND_NEITHER;
    end else if (colon_next == COLON_NEED) begin
      verdict = v6_fin ? KIND_V6 : KIND_NEITHER;
    end else begin
      verdict = KIND_NEITHER;
    end
  end

  // result buffer: head at slot 0
  always_comb begin
    logic [OB_CNT_W-1:0] base;
    base = ob_cnt - OB_CNT_W'(do_pop);
    for (int i = 0; i < OB_DEPTH - 1; i++) begin
      ob_next[i] = do_pop ? ob[i + 1] : ob[i];
    end
    ob_next[OB_DEPTH - 1] = ob[OB_DEPTH - 1];
    if (tok_pop && tok.last) begin
      ob_next[base[OB_CNT_W-2:0]] = verdict;
    end
    ob_cnt_next = base + OB_CNT_W'(tok_pop && tok.last);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < OB_DEPTH; i++) begin
      ob[i] <= ob_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_cnt      <= '0;
      dot_count   <= '0;
      colon_count <= '0;
      v4_ok       <= 1'b1;
      v6_ok       <= 1'b1;
      len4        <= '0;
      val4        <= '0;
      fz4         <= 1'b0;
      len6        <= '0;
    end else begin
      ob_cnt <= ob_cnt_next;
      if (tok_pop) begin
        if (tok.last) begin
          dot_count   <= '0;
          colon_count <= '0;
          v4_ok       <= 1'b1;
          v6_ok       <= 1'b1;
          len4        <= '0;
          val4        <= '0;
          fz4         <= 1'b0;
          len6        <= '0;
        end else begin
          dot_count   <= dot_next;
          colon_count <= colon_next;
          v4_ok       <= v4_ok_next;
          v6_ok       <= v6_ok_next;
          len4        <= len4_next;
          val4        <= val4_next;
          fz4         <= fz4_next;
          len6        <= len6_next;
        end
      end
    end
  end

endmodule

/* rtl/ip_address_text_validator_unit.sv */
// ----------------------------------------------------------------------------
// ip_address_text_validator_unit
// Checks an address string, one byte per request, as IPv4 and IPv6 at once.
// ----------------------------------------------------------------------------
// Takes one byte per clock while full is low: each byte is classified
// on entry and parked in a four-entry queue, and the scanner behind it
// updates both readings as it takes each byte, one byte per cycle but
// for holding a final byte while the result buffer is full. Only the
// byte flagged last yields a result (0 neither, 1 IPv4, 2 IPv6); it is
// written into the buffer as the scanner takes that byte and shows on
// address_kind once at its head; up to two results wait while pop is low.
`include "ip_address_text_validator_unit_assert.svh"

module ip_address_text_validator_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] char_code,
  input  logic       last,
  input  logic       push,
  output logic       full,
  output logic [1:0] address_kind,
  output logic       empty,
  input  logic       pop
);
  import ipav_pkg::*;

  tok_t  in_tok;
  tok_t  q_tok;
  logic  q_empty;
  logic  q_full;
  logic  tok_pop;
  kind_t kind;

  ipav_classify u_classify (
    .char_code (char_code),
    .last      (last),
    .tok       (in_tok)
  );

  ipav_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (push && !q_full),
    .wr_tok  (in_tok),
    .q_full  (q_full),
    .rd      (tok_pop),
    .rd_tok  (q_tok),
    .q_empty (q_empty)
  );

  ipav_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .tok_valid  (!q_empty),
    .tok        (q_tok),
    .tok_pop    (tok_pop),
    .kind_out   (kind),
    .kind_empty (empty),
    .kind_pop   (pop)
  );

  assign full         = q_full;
  assign address_kind = kind;

  `IPAV_ASSERT_RST(a_reset_clears, rst |=> (empty && !full), "reset left items queued")
  `IPAV_ASSERT(a_push_lands, (push && !full) |=> !q_empty, "accepted byte missing from queue")
  `IPAV_ASSERT(a_pop_nonempty, tok_pop |-> !q_empty, "scanner read an empty queue")

endmodule

/* sim/ip_address_text_validator_unit_tb.sv */
// ----------------------------------------------------------------------------
// ip_address_text_validator_unit_tb
// Self-checking bench for the IPv4/IPv6 address text validator. Address
// strings are pushed one byte per request. Some are well-formed IPv4 and
// IPv6 text with random content, some are broken on purpose, and some are
// noise. A scoreboard runs both readings byte by byte and checks the kind
// given for each final byte. Both sides idle at random, and one long
// receiver hold-off backs the block up until it stalls its input.
// ----------------------------------------------------------------------------
module ip_address_text_validator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ipav_pkg::*;

  localparam int TARGET_BYTES = 1850;
  localparam int HOLD_CYCLES  = 150;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PRINT_MAX    = 40;

  // Tracks both readings of the string in flight and queues the kind owed
  // for every final byte.
  class address_scoreboard;
    kind_t              kind_q[$];
    int unsigned        mismatches;
    int unsigned        n_v4, n_v6, n_none, n_bytes;
    logic [DOT_W-1:0]   dots;
    logic [COLON_W-1:0] colons;
    bit                 v4_ok, v6_ok;
    logic [LEN4_W-1:0]  v4_len;
    logic [VAL4_W-1:0]  v4_val;
    bit                 v4_lead0;
    logic [LEN6_W-1:0]  v6_len;

    function new();
      mismatches = 0;
      n_v4 = 0;
      n_v6 = 0;
      n_none = 0;
      n_bytes = 0;
      clear();
    endfunction

    function void clear();
      dots = '0;
      colons = '0;
      v4_ok = 1'b1;
      v6_ok = 1'b1;
      v4_len = '0;
      v4_val = '0;
      v4_lead0 = 1'b0;
      v6_len = '0;
    endfunction

    function void end_v4_group();
      if (v4_len == 0 || v4_len > LEN4_MAX || v4_val > VAL4_MAX || (v4_lead0 && v4_len != 1))
        v4_ok = 1'b0;
      v4_len = '0;
      v4_val = '0;
      v4_lead0 = 1'b0;
    endfunction

    function void end_v6_group();
      if (v6_len == 0 || v6_len > LEN6_MAX) v6_ok = 1'b0;
      v6_len = '0;
    endfunction

    function int pending();
      return kind_q.size();
    endfunction

    task report(string msg);
      if (mismatches < PRINT_MAX) $display("tb: mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    function void note_byte(logic [7:0] c, logic fin);
      bit    dec;
      bit    hex;
      kind_t k;
      dec = (c >= CHAR_DIG0) && (c <= CHAR_DIG9);
      hex = dec || (c >= CHAR_LA && c <= CHAR_LF) || (c >= CHAR_UA && c <= CHAR_UF);
      n_bytes++;

      if (c == CHAR_DOT) begin
        end_v4_group();
        if (dots < DOT_SAT) dots++;
      end else if (dec) begin
        if (v4_len == 0) v4_lead0 = (c == CHAR_DIG0);
        // only the first three digits build the value
        if (v4_len < LEN4_MAX) v4_val = v4_val * VAL4_RADIX + VAL4_W'(c - CHAR_DIG0);
        if (v4_len < LEN4_SAT) v4_len++;
      end else begin
        v4_ok = 1'b0;
      end

      if (c == CHAR_COLON) begin
        end_v6_group();
        if (colons < COLON_SAT) colons++;
      end else if (hex) begin
        if (v6_len < LEN6_SAT) v6_len++;
      end else begin
        v6_ok = 1'b0;
      end

      if (fin) begin
        end_v4_group();
        end_v6_group();
        if (dots == DOT_NEED) k = v4_ok ? KIND_V4 : KIND_NEITHER;
        else if (colons == COLON_NEED) k = v6_ok ? KIND_V6 : KIND_NEITHER;
        else k = KIND_NEITHER;
        case (k)
          KIND_V4: n_v4++;
          KIND_V6: n_v6++;
          default: n_none++;
        endcase
        kind_q = {kind_q, k};
        clear();
      end
    endfunction

    task check_kind(logic [1:0] got);
      kind_t want;
      if (kind_q.size() == 0) begin
        report($sformatf("address_kind %0d with no request pending", got));
      end else begin
        want = kind_q.pop_front();
        if (got !== want)
          report($sformatf("address_kind %0d, wanted %0d", got, want));
      end
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic [7:0] char_code = '0;
  logic       last = 1'b0;
  logic       push = 1'b0;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [1:0] address_kind;

  address_scoreboard sb = new();

  byte unsigned text_q[$];
  bit           calm = 1'b0;     // no random idling on either side
  bit           hold_req = 1'b0;
  int unsigned  rx_hold = 0;
  int unsigned  rx_stall = 0;
  int unsigned  cycle_count = 0;

  ip_address_text_validator_unit dut (
    .clk          (clk),
    .rst          (rst),
    .char_code    (char_code),
    .last         (last),
    .push         (push),
    .full         (full),
    .address_kind (address_kind),
    .empty        (empty),
    .pop          (pop)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // receiver: checks each popped result, then decides pop for the next cycle
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) sb.check_kind(address_kind);
      if (hold_req) begin
        rx_hold = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (rx_hold != 0) begin
        rx_hold--;
        pop <= 1'b0;
      end else if (calm) begin
        pop <= 1'b1;
      end else if (rx_stall != 0) begin
        rx_stall--;
        pop <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        rx_stall = pick_gap() - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic void put_byte(byte unsigned b);
    text_q = {text_q, b};
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic byte unsigned hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'(CHAR_DIG0 + v);
    return 8'(($urandom_range(0, 1) ? CHAR_UA : CHAR_LA) + v - 10);
  endfunction

  function automatic byte unsigned pick_sep(logic [7:0] sep);
    if ($urandom_range(0, 19) != 0) return sep;
    if ($urandom_range(0, 1) != 0) return (sep == CHAR_DOT) ? CHAR_COLON : CHAR_DOT;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void gen_v4_text();
    int ngrp;
    int r;
    ngrp = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 5) : 4;
    for (int g = 0; g < ngrp; g++) begin
      if (g != 0) put_byte(pick_sep(CHAR_DOT));
      r = $urandom_range(0, 99);
      if (r < 70)      add_str($sformatf("%0d", $urandom_range(0, 255)));
      else if (r < 78) add_str($sformatf("%0d", $urandom_range(256, 999)));
      else if (r < 86) add_str($sformatf("0%0d", $urandom_range(0, 99)));
      else if (r < 93) add_str($sformatf("%0d", $urandom_range(1000, 99999)));
      else if (r >= 97) put_byte(hex_char());
      // 93..96 leaves the group empty
    end
  endfunction

  function automatic void gen_v6_text();
    int ngrp;
    int r;
    int len;
    ngrp = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 9) : 8;
    for (int g = 0; g < ngrp; g++) begin
      if (g != 0) put_byte(pick_sep(CHAR_COLON));
      r = $urandom_range(0, 99);
      if (r < 90)      len = $urandom_range(1, 4);
      else if (r < 95) len = 0;
      else             len = $urandom_range(5, 6);
      for (int i = 0; i < len; i++) put_byte(hex_char());
    end
  endfunction

  function automatic void gen_noise_text();
    string charset;
    int    len;
    charset = ".:0123456789abcdefABCDEF";
    len = $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 1) != 0) put_byte(8'($urandom_range(0, 255)));
      else put_byte(charset[$urandom_range(0, charset.len() - 1)]);
    end
  endfunction

  // pushes text_q, last set on its final byte
  task automatic send_text();
    int   gap;
    logic fin;
    for (int i = 0; i < text_q.size(); i++) begin
      gap = (!calm && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      fin = (i == text_q.size() - 1);
      push <= 1'b1;
      char_code <= text_q[i];
      last <= fin;
      do @(posedge clk); while (full);
      sb.note_byte(text_q[i], fin);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    string dir_texts[$];
    int    sel;
    int    blk;

    dir_texts = '{"1.2.3.4", "255.255.255.255", "0.0.0.0", "256.1.1.1", "01.1.1.1",
                  "1234.1.1.1", "1.2.3.", ".1.2.3", "1..2.3", "1.2.3.4.5", "1.2.3.g",
                  "2001:db8:85a3:0:0:8A2E:370:7334", "ffff:FFFF:0:0:0:0:0:0",
                  "1::2:3:4:5:6:7", "12345:1:2:3:4:5:6:7", "1:2:3:4:5:6:7:",
                  "1:2:3:4:5:6:7:8:9", "1.2.3.4:::::::", "a", ":", "."};
    blk = 0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_texts[i]) begin
      text_q.delete();
      add_str(dir_texts[i]);
      send_text();
    end
    // high bytes in each reading
    text_q.delete();
    add_str("1.2.3.");
    put_byte(8'hFF);
    send_text();
    text_q.delete();
    add_str("1:2:3:4:5:6:7:");
    put_byte(8'h80);
    send_text();
    drain();

    // receiver holds off while single-byte strings keep coming: input backs up
    calm = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 24; i++) begin
      text_q.delete();
      put_byte(8'(CHAR_DIG0 + $urandom_range(0, 9)));
      send_text();
    end
    calm = 1'b0;
    drain();

    while (sb.n_bytes < TARGET_BYTES) begin
      if (blk == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        blk = $urandom_range(10, 40);
      end
      blk--;
      text_q.delete();
      sel = $urandom_range(0, 99);
      if (sel < 38) gen_v4_text();
      else if (sel < 76) gen_v6_text();
      else gen_noise_text();
      if (sel < 76 && $urandom_range(0, 5) == 0)
        text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
      send_text();
    end
    push <= 1'b0;
    calm = 1'b0;

    drain();
    repeat (10) @(posedge clk);

    $display("tb: %0d strings over %0d bytes: %0d IPv4, %0d IPv6, %0d neither",
             sb.n_v4 + sb.n_v6 + sb.n_none, sb.n_bytes, sb.n_v4, sb.n_v6, sb.n_none);
    $display("tb: random idling, stall-free stretches and a %0d-cycle pop hold-off",
             HOLD_CYCLES);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", sb.mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/ipav_pkg.sv
rtl/ipav_classify.sv
rtl/ipav_fifo.sv
rtl/ipav_scan.sv
rtl/ip_address_text_validator_unit.sv
sim/ip_address_text_validator_unit_tb.sv
